>>> rtl/uspc_pkg.sv
// Types and constants shared by the UDP session packet classifier.
package uspc_pkg;

  localparam logic [15:0] ETHER_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [15:0] HEADER_BYTES  = 16'd42;
  localparam logic [15:0] BATCH_HDR     = 16'd24;
  localparam logic [10:0] RECORD_HDR    = 11'd8;
  localparam logic [3:0]  MAX_BATCH     = 4'd10;

  localparam logic [7:0]  JOIN_CODE     = 8'd0;
  localparam logic [7:0]  INPUT_CODE    = 8'd2;
  localparam logic [7:0]  STATS_CODE    = 8'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LISTEN_PORT   = 3'd0,
    REG_INITIAL_SEQ   = 3'd1,
    REG_BATCH_LIMIT   = 3'd2,
    REG_RECORD_BYTES  = 3'd3,
    REG_JOIN_MIN      = 3'd4,
    REG_INPUT_MIN     = 3'd5,
    REG_STATS_MIN     = 3'd6,
    REG_UNUSED        = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_DROP     = 2'd1,
    VERDICT_TRANSMIT = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_JOIN  = 2'd1,
    KIND_STATS = 2'd2
  } resp_kind_t;

endpackage

>>> rtl/udp_session_packet_classifier.sv
// Top level of the UDP session packet classifier with its session table.
//
// Usage:
//   s_axis_* takes one parsed packet summary per request; m_axis_* returns one
//   verdict per request in the same order. cfg_* writes one register per
//   request (always ready) and must only be used while the block is idle.
//   The summary is captured in an input register; the session table lookup
//   (a parallel compare of the key against every slot), the LRU victim pick,
//   the classification and the batch arithmetic all resolve before the
//   result register, so each verdict goes through the input register and
//   then the result register. Throughput is 1 request per cycle while
//   m_axis_tready stays high; the session table is updated at the same
//   edge that loads the result, so back-to-back packets see each other's
//   table changes.
//   Reset empties the table, sets the recency ranks to slot order and loads
//   the register defaults; no clearing pass is needed.
//   When m_axis_tready is low the result holds, the input register holds
//   its request and s_axis_tready drops once both stages are full.
module udp_session_packet_classifier
  import uspc_pkg::*;
#(
  parameter int SESSION_SLOTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] ether_type, [23:16] ip_protocol, [39:24] udp_dest_port,
  // [55:40] frame_length, [119:56] client_key, [183:120] sequence_req
  input  logic [183:0]           s_axis_tdata,
  // [7:0] msg_type
  input  logic [7:0]             s_axis_tuser,

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] verdict, [2] session_created, [6:3] forwarded_count,
  // [22:7] forwarded_bytes, [23] zero
  output logic [23:0]            m_axis_tdata,
  // [1:0] response_kind
  output logic [1:0]             m_axis_tuser,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int RANK_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
  localparam logic [RANK_W-1:0] LRU_RANK = RANK_W'(SESSION_SLOTS - 1);

  // Configuration registers
  logic [15:0] listen_port;
  logic [63:0] initial_sequence;
  logic [3:0]  batch_limit;
  logic [9:0]  input_record_bytes;
  logic [9:0]  join_min_bytes;
  logic [15:0] input_min_bytes;
  logic [9:0]  stats_min_bytes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_port        <= 16'd40000;
      initial_sequence   <= 64'd1000;
      batch_limit        <= 4'd10;
      input_record_bytes <= 10'd64;
      join_min_bytes     <= 10'd9;
      input_min_bytes    <= 16'd33;
      stats_min_bytes    <= 10'd17;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LISTEN_PORT:  listen_port        <= cfg_data[15:0];
        REG_INITIAL_SEQ:  initial_sequence   <= cfg_data;
        REG_BATCH_LIMIT:  batch_limit        <= cfg_data[3:0];
        REG_RECORD_BYTES: input_record_bytes <= cfg_data[9:0];
        REG_JOIN_MIN:     join_min_bytes     <= cfg_data[9:0];
        REG_INPUT_MIN:    input_min_bytes    <= cfg_data[15:0];
        REG_STATS_MIN:    stats_min_bytes    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic        in_valid;
  logic [15:0] in_ether_type;
  logic [7:0]  in_ip_protocol;
  logic [15:0] in_udp_dest_port;
  logic [15:0] in_frame_length;
  logic [7:0]  in_msg_type;
  logic [63:0] in_client_key;
  logic [63:0] in_sequence_req;

  logic advance;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ether_type    <= s_axis_tdata[15:0];
      in_ip_protocol   <= s_axis_tdata[23:16];
      in_udp_dest_port <= s_axis_tdata[39:24];
      in_frame_length  <= s_axis_tdata[55:40];
      in_client_key    <= s_axis_tdata[119:56];
      in_sequence_req  <= s_axis_tdata[183:120];
      in_msg_type      <= s_axis_tuser;
    end
  end

  // Session table
  logic [SESSION_SLOTS-1:0] slot_valid;
  logic [63:0]              slot_key           [SESSION_SLOTS];
  logic [63:0]              slot_next_sequence [SESSION_SLOTS];
  logic [RANK_W-1:0]        slot_recency       [SESSION_SLOTS];

  logic [SESSION_SLOTS-1:0] match;
  logic [SESSION_SLOTS-1:0] free_slots;
  logic [SESSION_SLOTS-1:0] free_first;
  logic [SESSION_SLOTS-1:0] lru_slot;
  logic [SESSION_SLOTS-1:0] victim;
  logic [SESSION_SLOTS-1:0] touch_sel;
  logic [63:0]              hit_next;
  logic [RANK_W-1:0]        touch_rank;
  logic                     hit;

  always_comb begin
    hit_next   = '0;
    touch_rank = '0;
    for (int i = 0; i < SESSION_SLOTS; i++) begin
      match[i]    = slot_valid[i] && (slot_key[i] == in_client_key);
      lru_slot[i] = (slot_recency[i] == LRU_RANK);
    end
    hit        = |match;
    free_slots = ~slot_valid;
    // Isolate the lowest free slot
    free_first = free_slots & (~free_slots + SESSION_SLOTS'(1));
    victim     = (|free_slots) ? free_first : lru_slot;
    touch_sel  = hit ? match : victim;
    for (int i = 0; i < SESSION_SLOTS; i++) begin
      hit_next   = hit_next | (match[i] ? slot_next_sequence[i] : 64'd0);
      touch_rank = touch_rank | (touch_sel[i] ? slot_recency[i] : '0);
    end
  end

  // Classification
  logic        is_pass;
  logic [15:0] payload;
  logic        has_payload;
  logic        join_ok;
  logic        input_ok;
  logic        stats_ok;
  logic        join_sel;
  logic        input_sel;
  logic        stats_sel;
  logic        insert;
  logic        input_hit;
  logic        seq_fresh;
  logic        touch_en;
  logic [3:0]  lim;
  logic [63:0] gap;
  logic [3:0]  batch_n;
  logic [10:0] record_span;
  logic [14:0] batch_prod;
  logic [15:0] need;
  logic        forward;

  always_comb begin
    is_pass = (in_frame_length < HEADER_BYTES) || (in_ether_type != ETHER_IPV4) ||
              (in_ip_protocol != PROTO_UDP) || (in_udp_dest_port != listen_port);
    payload     = in_frame_length - HEADER_BYTES;
    has_payload = !is_pass && (payload != 16'd0);
    join_ok     = (in_msg_type == JOIN_CODE)  && (payload >= {6'd0, join_min_bytes});
    input_ok    = (in_msg_type == INPUT_CODE) && (payload >= input_min_bytes);
    stats_ok    = (in_msg_type == STATS_CODE) && (payload >= {6'd0, stats_min_bytes});
    join_sel    = has_payload && join_ok;
    input_sel   = has_payload && !join_ok && input_ok;
    stats_sel   = has_payload && !join_ok && !input_ok && stats_ok;

    insert    = join_sel && !hit;
    input_hit = input_sel && hit;
    seq_fresh = in_sequence_req >= hit_next;
    touch_en  = insert || input_hit;

    priority if (batch_limit == 4'd0) lim = 4'd1;
    else if (batch_limit > MAX_BATCH) lim = MAX_BATCH;
    else lim = batch_limit;

    gap     = in_sequence_req - hit_next;
    batch_n = (gap >= {60'd0, lim}) ? lim : (gap[3:0] + 4'd1);

    // At most 10 * 1031 + 24, so never reaches the 16-bit ceiling
    record_span = {1'b0, input_record_bytes} + RECORD_HDR;
    batch_prod  = 15'(batch_n * record_span);
    need        = BATCH_HDR + {1'b0, batch_prod};
    forward     = input_hit && seq_fresh && (payload > need);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      for (int i = 0; i < SESSION_SLOTS; i++) begin
        slot_recency[i] <= RANK_W'(i);
      end
    end else if (advance) begin
      for (int i = 0; i < SESSION_SLOTS; i++) begin
        if (insert && victim[i]) begin
          slot_valid[i] <= 1'b1;
        end
        if (touch_en) begin
          if (touch_sel[i]) begin
            slot_recency[i] <= '0;
          end else if (slot_recency[i] < touch_rank) begin
            slot_recency[i] <= slot_recency[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < SESSION_SLOTS; i++) begin
        if (insert && victim[i]) begin
          slot_key[i]           <= in_client_key;
          slot_next_sequence[i] <= initial_sequence;
        end else if (input_hit && seq_fresh && match[i]) begin
          slot_next_sequence[i] <= in_sequence_req + 64'd1;
        end
      end
    end
  end

  // Result register
  verdict_t   out_verdict;
  resp_kind_t out_kind;
  logic       out_created;
  logic [3:0] out_count;
  logic [15:0] out_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (is_pass) begin
        out_verdict <= VERDICT_PASS;
      end else if (join_sel || stats_sel) begin
        out_verdict <= VERDICT_TRANSMIT;
      end else begin
        out_verdict <= VERDICT_DROP;
      end
      out_kind    <= join_sel ? KIND_JOIN : (stats_sel ? KIND_STATS : KIND_NONE);
      out_created <= insert;
      out_count   <= forward ? batch_n : 4'd0;
      out_bytes   <= forward ? need : 16'd0;
    end
  end

  assign m_axis_tdata = {1'b0, out_bytes, out_count, out_created, out_verdict};
  assign m_axis_tuser = out_kind;

  // A key lives in at most one slot
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("session key matches more than one slot");

  // Recency ranks stay a permutation, so exactly one slot is least recent
  a_one_lru: assert property (@(posedge clk) disable iff (rst)
    $countones(lru_slot) == 1)
    else $error("recency ranks lost their single oldest slot");

  // A passed packet carries no response, session or batch
  a_pass_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_verdict == VERDICT_PASS) |->
      (out_kind == KIND_NONE) && !out_created && (out_count == 4'd0))
    else $error("passed packet carries side results");

  // A created session appears only on a join response
  a_created_join: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_created |-> (out_kind == KIND_JOIN))
    else $error("session created outside a join");

  // An inserted slot is marked valid on the next cycle
  a_insert_hits: assert property (@(posedge clk) disable iff (rst)
    advance && insert |=> $past(victim) == (slot_valid & $past(victim)))
    else $error("inserted slot not marked valid");

  a_batch_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_count <= MAX_BATCH))
    else $error("forwarded count above batch maximum");

endmodule

>>> tb/udp_session_packet_classifier_tb.sv
// Self-checking testbench for the UDP session packet classifier and its session table.
`timescale 1ns / 1ps

module udp_session_packet_classifier_tb;
  import uspc_pkg::*;

  localparam int SLOTS        = 64;
  localparam int KEY_POOL     = 72;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 272;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PAYLOAD  = 65493;

  localparam logic [15:0] DEF_PORT      = 16'd40000;
  localparam logic [63:0] DEF_INIT_SEQ  = 64'd1000;
  localparam logic [3:0]  DEF_BATCH     = 4'd10;
  localparam logic [9:0]  DEF_RECORD    = 10'd64;
  localparam logic [9:0]  DEF_JOIN_MIN  = 10'd9;
  localparam logic [15:0] DEF_INPUT_MIN = 16'd33;
  localparam logic [9:0]  DEF_STATS_MIN = 10'd17;
  localparam logic [63:0] ALL_ONES      = '1;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] udp_dest_port;
    logic [15:0] frame_length;
    logic [7:0]  msg_type;
    logic [63:0] client_key;
    logic [63:0] sequence_req;
  } pkt_t;

  typedef struct packed {
    verdict_t    verdict;
    resp_kind_t  kind;
    logic        created;
    logic [3:0]  count;
    logic [15:0] bytes;
  } verdict_rec_t;

  typedef struct {
    pkt_t         pkt;
    bit           typed;
    verdict_rec_t want;
  } plan_row_t;

  typedef struct {
    logic [15:0] port;
    logic [63:0] init_seq;
    logic [3:0]  batch;
    logic [9:0]  record;
    logic [9:0]  join_min;
    logic [15:0] input_min;
    logic [9:0]  stats_min;
  } cfg_set_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [183:0]           s_axis_tdata = '0;
  logic [7:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [23:0]            m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Session table and registers as the classifier should hold them
  logic [63:0] sess_key [SLOTS];
  logic [63:0] sess_next [SLOTS];
  bit          sess_live [SLOTS];
  int unsigned sess_rank [SLOTS];
  logic [15:0] cur_port;
  logic [63:0] cur_init_seq;
  logic [3:0]  cur_batch;
  logic [9:0]  cur_record;
  logic [9:0]  cur_join_min;
  logic [15:0] cur_input_min;
  logic [9:0]  cur_stats_min;

  verdict_rec_t verdicts_due [$];
  logic [63:0]  key_pool [KEY_POOL];
  int           mismatch_count = 0;
  int           cycles = 0;
  bit           gaps_on = 1'b1;

  udp_session_packet_classifier i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int find_session(logic [63:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (sess_live[i] && sess_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void mark_recent(int s);
    int unsigned old_rank;
    old_rank = sess_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (sess_rank[i] < old_rank) sess_rank[i]++;
    sess_rank[s] = 0;
  endfunction

  // Lowest free slot first, else the least recently used one
  function automatic int pick_slot();
    int oldest;
    oldest = 0;
    for (int i = 0; i < SLOTS; i++)
      if (!sess_live[i]) return i;
    for (int i = 1; i < SLOTS; i++)
      if (sess_rank[i] > sess_rank[oldest]) oldest = i;
    return oldest;
  endfunction

  function automatic int unsigned batch_cap();
    if (cur_batch == 4'd0) return 1;
    if (cur_batch > MAX_BATCH) return 32'(MAX_BATCH);
    return 32'(cur_batch);
  endfunction

  function automatic int unsigned batch_size(logic [63:0] seq, logic [63:0] next);
    logic [63:0] gap;
    gap = seq - next;
    if (gap >= 64'(batch_cap())) return batch_cap();
    return gap[31:0] + 32'd1;
  endfunction

  function automatic int unsigned batch_bytes(int unsigned n);
    return 32'(BATCH_HDR) + n * (32'(RECORD_HDR) + 32'(cur_record));
  endfunction

  function automatic verdict_rec_t classify_packet(pkt_t p);
    verdict_rec_t r;
    int unsigned  payload, n, need;
    int           s;
    r.verdict = VERDICT_DROP;
    r.kind    = KIND_NONE;
    r.created = 1'b0;
    r.count   = '0;
    r.bytes   = '0;
    if (p.ether_type != ETHER_IPV4 || p.ip_protocol != PROTO_UDP ||
        p.frame_length < HEADER_BYTES || p.udp_dest_port != cur_port) begin
      r.verdict = VERDICT_PASS;
      return r;
    end
    payload = 32'(p.frame_length) - 32'(HEADER_BYTES);
    if (payload == 0) return r;
    if (p.msg_type == JOIN_CODE && payload >= 32'(cur_join_min)) begin
      if (find_session(p.client_key) < 0) begin
        s = pick_slot();
        sess_key[s]  = p.client_key;
        sess_next[s] = cur_init_seq;
        sess_live[s] = 1'b1;
        mark_recent(s);
        r.created = 1'b1;
      end
      r.verdict = VERDICT_TRANSMIT;
      r.kind    = KIND_JOIN;
    end else if (p.msg_type == INPUT_CODE && payload >= 32'(cur_input_min)) begin
      s = find_session(p.client_key);
      if (s >= 0) begin
        mark_recent(s);
        if (p.sequence_req >= sess_next[s]) begin
          n = batch_size(p.sequence_req, sess_next[s]);
          sess_next[s] = p.sequence_req + 64'd1;
          need = batch_bytes(n);
          if (payload > need) begin
            r.count = n[3:0];
            r.bytes = (need > 32'hFFFF) ? 16'hFFFF : need[15:0];
          end
        end
      end
    end else if (p.msg_type == STATS_CODE && payload >= 32'(cur_stats_min)) begin
      r.verdict = VERDICT_TRANSMIT;
      r.kind    = KIND_STATS;
    end
    return r;
  endfunction

  function automatic pkt_t mk_pkt(logic [15:0] ether, logic [7:0] proto, logic [15:0] port,
                                  logic [15:0] flen, logic [7:0] ptype, logic [63:0] key,
                                  logic [63:0] seq);
    pkt_t p;
    p.ether_type    = ether;
    p.ip_protocol   = proto;
    p.udp_dest_port = port;
    p.frame_length  = flen;
    p.msg_type      = ptype;
    p.client_key    = key;
    p.sequence_req  = seq;
    return p;
  endfunction

  function automatic pkt_t udp_to(logic [15:0] flen, logic [7:0] ptype, logic [63:0] key,
                                  logic [63:0] seq);
    return mk_pkt(ETHER_IPV4, PROTO_UDP, DEF_PORT, flen, ptype, key, seq);
  endfunction

  function automatic verdict_rec_t mk_verdict(verdict_t v, resp_kind_t k, logic created);
    verdict_rec_t r;
    r.verdict = v;
    r.kind    = k;
    r.created = created;
    r.count   = '0;
    r.bytes   = '0;
    return r;
  endfunction

  // Mostly well-formed requests to the listened port, aimed at live sessions
  function automatic pkt_t gen_packet();
    pkt_t        p;
    int          roll, pick, s;
    int unsigned payload, floor_bytes;
    logic [63:0] next;
    roll = $urandom_range(0, 99);
    p.ether_type    = ETHER_IPV4;
    p.ip_protocol   = PROTO_UDP;
    p.udp_dest_port = cur_port;
    p.client_key    = key_pool[$urandom_range(0, KEY_POOL - 1)];
    p.sequence_req  = {$urandom, $urandom};
    if (roll < 12) begin
      p.ether_type    = 16'($urandom);
      p.ip_protocol   = 8'($urandom);
      p.udp_dest_port = 16'($urandom);
      p.frame_length  = 16'($urandom);
      p.msg_type      = 8'($urandom);
      p.client_key    = {$urandom, $urandom};
      return p;
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) p.msg_type = JOIN_CODE;
    else if (pick < 75) p.msg_type = INPUT_CODE;
    else if (pick < 90) p.msg_type = STATS_CODE;
    else p.msg_type = 8'($urandom);
    if ($urandom_range(0, 19) == 0) p.client_key = {$urandom, $urandom};

    floor_bytes = 1;
    if (p.msg_type == JOIN_CODE) floor_bytes = 32'(cur_join_min);
    else if (p.msg_type == STATS_CODE) floor_bytes = 32'(cur_stats_min);
    else if (p.msg_type == INPUT_CODE) begin
      floor_bytes = 32'(cur_input_min);
      s = find_session(p.client_key);
      if (s >= 0) begin
        next = sess_next[s];
        case ($urandom_range(0, 9))
          0:       p.sequence_req = next - 64'd1 - 64'($urandom_range(0, 3));
          1:       ;
          2, 3:    p.sequence_req = next;
          default: p.sequence_req = next + 64'($urandom_range(1, 14));
        endcase
        // aim the payload at the size that just fits the batch
        if (p.sequence_req >= next &&
            batch_bytes(batch_size(p.sequence_req, next)) + 1 > floor_bytes)
          floor_bytes = batch_bytes(batch_size(p.sequence_req, next)) + 1;
      end
    end
    case ($urandom_range(0, 5))
      0:       payload = (floor_bytes > 0) ? floor_bytes - 1 : 0;
      1, 2:    payload = floor_bytes;
      3:       payload = floor_bytes + $urandom_range(0, 40);
      4:       payload = $urandom_range(1, 2000);
      default: payload = $urandom_range(0, MAX_PAYLOAD);
    endcase
    if (payload > MAX_PAYLOAD) payload = MAX_PAYLOAD;
    p.frame_length = 16'(payload + 32'(HEADER_BYTES));

    // break one header field
    if (roll < 22) begin
      case ($urandom_range(0, 3))
        0:       p.ether_type = 16'($urandom);
        1:       p.ip_protocol = 8'($urandom);
        2:       p.udp_dest_port = 16'($urandom);
        default: p.frame_length = 16'($urandom_range(0, HEADER_BYTES));
      endcase
    end
    return p;
  endfunction

  function automatic cfg_set_t phase_cfg(int ph);
    cfg_set_t c;
    c = '{DEF_PORT, DEF_INIT_SEQ, DEF_BATCH, DEF_RECORD, DEF_JOIN_MIN, DEF_INPUT_MIN,
          DEF_STATS_MIN};
    case (ph)
      0: c = '{16'd0, 64'd0, 4'd1, 10'd0, 10'd1, 16'd1, 10'd1};
      1: c = '{16'hFFFF, 64'hFFFF_FFFF_FFFF_FFF0, 4'd10, 10'd1023, 10'd1023, 16'hFFFF,
               10'd1023};
      2: begin
        c.port      = 16'($urandom);
        c.init_seq  = {$urandom, $urandom};
        c.batch     = 4'($urandom_range(1, 10));
        c.record    = 10'($urandom_range(0, 200));
        c.join_min  = 10'($urandom_range(1, 64));
        c.input_min = 16'($urandom_range(17, 300));
        c.stats_min = 10'($urandom_range(1, 64));
      end
      3: c = '{DEF_PORT, ALL_ONES, 4'd0, 10'd1023, 10'd0, 16'd0, 10'd0};
      4: begin
        c.port      = 16'($urandom);
        c.init_seq  = {$urandom, $urandom};
        c.batch     = 4'd15;
        c.record    = 10'd5;
        c.join_min  = 10'($urandom_range(1, 30));
        c.input_min = 16'($urandom_range(1, 100));
        c.stats_min = 10'($urandom_range(1, 30));
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_packet(pkt_t p, bit typed, verdict_rec_t want);
    verdict_rec_t predicted;
    if (gaps_on)
      while ($urandom_range(0, 99) < 12) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.sequence_req, p.client_key, p.frame_length, p.udp_dest_port,
                      p.ip_protocol, p.ether_type};
    s_axis_tuser  <= p.msg_type;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = classify_packet(p);
    verdicts_due.push_back(typed ? want : predicted);
  endtask

  // Hold off new requests until every verdict is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LISTEN_PORT:  cur_port      = value[15:0];
      REG_INITIAL_SEQ:  cur_init_seq  = value;
      REG_BATCH_LIMIT:  cur_batch     = value[3:0];
      REG_RECORD_BYTES: cur_record    = value[9:0];
      REG_JOIN_MIN:     cur_join_min  = value[9:0];
      REG_INPUT_MIN:    cur_input_min = value[15:0];
      REG_STATS_MIN:    cur_stats_min = value[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(cfg_set_t c);
    write_reg(REG_LISTEN_PORT, 64'(c.port));
    write_reg(REG_INITIAL_SEQ, c.init_seq);
    write_reg(REG_BATCH_LIMIT, 64'(c.batch));
    write_reg(REG_RECORD_BYTES, 64'(c.record));
    write_reg(REG_JOIN_MIN, 64'(c.join_min));
    write_reg(REG_INPUT_MIN, 64'(c.input_min));
    write_reg(REG_STATS_MIN, 64'(c.stats_min));
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [15:0] expv, logic [15:0] gotv);
    if (gotv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, gotv);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : watch_results
    verdict_rec_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict with no request outstanding");
        mismatch_count++;
      end else begin
        want = verdicts_due.pop_front();
        check_field("verdict", 16'(want.verdict), 16'(m_axis_tdata[1:0]));
        check_field("response_kind", 16'(want.kind), 16'(m_axis_tuser));
        check_field("session_created", 16'(want.created), 16'(m_axis_tdata[2]));
        check_field("forwarded_count", 16'(want.count), 16'(m_axis_tdata[6:3]));
        check_field("forwarded_bytes", want.bytes, m_axis_tdata[22:7]);
      end
    end
    m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    plan_row_t    plan [$];
    verdict_rec_t pass_v, drop_v, join_new, join_old, stats_v;

    for (int i = 0; i < SLOTS; i++) begin
      sess_key[i]  = '0;
      sess_next[i] = '0;
      sess_live[i] = 1'b0;
      sess_rank[i] = i;
    end
    cur_port      = DEF_PORT;
    cur_init_seq  = DEF_INIT_SEQ;
    cur_batch     = DEF_BATCH;
    cur_record    = DEF_RECORD;
    cur_join_min  = DEF_JOIN_MIN;
    cur_input_min = DEF_INPUT_MIN;
    cur_stats_min = DEF_STATS_MIN;

    key_pool[0] = '0;
    key_pool[1] = 64'd1;
    key_pool[2] = ALL_ONES;
    for (int i = 3; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

    pass_v   = mk_verdict(VERDICT_PASS, KIND_NONE, 1'b0);
    drop_v   = mk_verdict(VERDICT_DROP, KIND_NONE, 1'b0);
    join_new = mk_verdict(VERDICT_TRANSMIT, KIND_JOIN, 1'b1);
    join_old = mk_verdict(VERDICT_TRANSMIT, KIND_JOIN, 1'b0);
    stats_v  = mk_verdict(VERDICT_TRANSMIT, KIND_STATS, 1'b0);

    // Reset register values apply throughout this table
    plan.push_back('{mk_pkt('0, '0, '0, '0, '0, '0, '0), 1'b1, pass_v});
    plan.push_back('{udp_to(16'd34, STATS_CODE, '0, '0), 1'b1, pass_v});
    plan.push_back('{udp_to(16'd41, JOIN_CODE, 64'd1, '0), 1'b1, pass_v});
    plan.push_back('{mk_pkt(16'h86DD, PROTO_UDP, DEF_PORT, 16'd100, JOIN_CODE, 64'd1, '0),
                     1'b1, pass_v});
    plan.push_back('{mk_pkt(ETHER_IPV4, 8'd6, DEF_PORT, 16'd100, JOIN_CODE, 64'd1, '0),
                     1'b1, pass_v});
    plan.push_back('{mk_pkt(ETHER_IPV4, PROTO_UDP, DEF_PORT - 16'd1, 16'd100, JOIN_CODE,
                            64'd1, '0), 1'b1, pass_v});
    plan.push_back('{mk_pkt('1, '1, '1, '1, '1, '1, '1), 1'b1, pass_v});
    plan.push_back('{udp_to(16'd42, JOIN_CODE, 64'd1, '0), 1'b1, drop_v});
    plan.push_back('{udp_to(16'd200, 8'hFF, 64'd1, '0), 1'b1, drop_v});
    plan.push_back('{udp_to(16'd200, 8'd1, 64'd1, '0), 1'b1, drop_v});
    plan.push_back('{udp_to(16'd200, 8'd3, 64'd1, '0), 1'b1, drop_v});
    plan.push_back('{udp_to(16'd50, JOIN_CODE, 64'd1, '0), 1'b1, drop_v});
    plan.push_back('{udp_to(16'd51, JOIN_CODE, 64'd1, '0), 1'b1, join_new});
    plan.push_back('{udp_to(16'd51, JOIN_CODE, 64'd1, '0), 1'b1, join_old});
    plan.push_back('{udp_to(16'd1500, INPUT_CODE, 64'd2, 64'd1000), 1'b1, drop_v});
    plan.push_back('{udp_to(16'd1500, INPUT_CODE, 64'd1, 64'd999), 1'b1, drop_v});
    plan.push_back('{udp_to(16'd74, INPUT_CODE, 64'd1, 64'd1000), 1'b1, drop_v});
    plan.push_back('{udp_to(16'd1500, INPUT_CODE, 64'd1, 64'd1000), 1'b0, '0});
    plan.push_back('{udp_to(16'd138, INPUT_CODE, 64'd1, 64'd1001), 1'b0, '0});
    plan.push_back('{udp_to(16'd787, INPUT_CODE, 64'd1, 64'd1102), 1'b0, '0});
    plan.push_back('{udp_to('1, INPUT_CODE, 64'd1, ALL_ONES), 1'b0, '0});
    plan.push_back('{udp_to(16'd1500, INPUT_CODE, 64'd1, '0), 1'b0, '0});
    plan.push_back('{udp_to(16'd59, STATS_CODE, '0, '0), 1'b1, stats_v});
    plan.push_back('{udp_to(16'd58, STATS_CODE, '0, '0), 1'b1, drop_v});
    plan.push_back('{udp_to('1, JOIN_CODE, ALL_ONES, ALL_ONES), 1'b1, join_new});
    plan.push_back('{udp_to(16'd1500, INPUT_CODE, ALL_ONES, 64'd1005), 1'b0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_packet(plan[i].pkt, plan[i].typed, plan[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      apply_cfg(phase_cfg(ph));
      // in phase 2 the source sends without gaps and the sink is always ready
      gaps_on <= (ph != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) drain_results();
        send_packet(gen_packet(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && verdicts_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
